@@ rtl/sasd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared types and constants of the scrambled ADPCM stereo decoder.
// ----------------------------------------------------------------------------
package sasd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 14;
  localparam int KEY_W    = 15;
  localparam int NIB_W    = 4;
  localparam int COEF_W   = 16;

  localparam int OP_W     = 2;
  localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA   = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF1      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF2      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MULT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ADD    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_KEY   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIX        = 3'd6;

  localparam int PRED_SHIFT = 12;

  // x/10 for 0 <= x < 2^19 as (x * ceil(2^22/10)) >> 22
  localparam int MIX_ABS_W = 19;
  localparam int MIX_SHIFT = 22;
  localparam logic [MIX_ABS_W-1:0] MIX_RECIP = 19'd419431;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  typedef struct packed {
    logic clear;
    logic scale_load;
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

@@ rtl/sasd_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_lane
// One channel core: scale, two-tap history, predictor products and sample sum.
// ----------------------------------------------------------------------------
module sasd_lane (
  input  logic                                        clk,
  input  logic                                        rst,
  input  sasd_pkg::lane_ctrl_t                        ctrl,
  input  logic [sasd_pkg::SCALE_W-1:0]                scale_value,
  input  logic signed [sasd_pkg::COEF_W-1:0]          coef1,
  input  logic signed [sasd_pkg::COEF_W-1:0]          coef2,
  input  logic signed [sasd_pkg::NIB_W-1:0]           nibble,
  output logic signed [sasd_pkg::SAMPLE_W-1:0]        sample
);

  logic [sasd_pkg::SCALE_W-1:0]          scale;
  logic signed [sasd_pkg::SAMPLE_W-1:0]  hist0;
  logic signed [sasd_pkg::SAMPLE_W-1:0]  hist1;
  logic signed [31:0]                    prod1;
  logic signed [31:0]                    prod2;

  logic signed [32:0]                    pred;
  logic signed [20:0]                    pred_sh;
  logic signed [18:0]                    step;
  logic signed [21:0]                    total;
  logic signed [sasd_pkg::SAMPLE_W-1:0]  sample_next;

  assign pred    = $signed({prod1[31], prod1}) + $signed({prod2[31], prod2});
  assign pred_sh = pred[32:sasd_pkg::PRED_SHIFT];
  assign step    = nibble * $signed({1'b0, scale});
  assign total   = $signed({pred_sh[20], pred_sh}) + $signed({{3{step[18]}}, step});

  always_comb begin
    if (total > $signed({{6{1'b0}}, sasd_pkg::SAMPLE_MAX})) begin
      sample_next = sasd_pkg::SAMPLE_MAX;
    end else if (total < $signed({{6{1'b1}}, sasd_pkg::SAMPLE_MIN})) begin
      sample_next = sasd_pkg::SAMPLE_MIN;
    end else begin
      sample_next = total[sasd_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= sasd_pkg::SCALE_W'(1);
      hist0 <= '0;
      hist1 <= '0;
    end else begin
      if (ctrl.scale_load) begin
        scale <= scale_value;
      end
      if (ctrl.clear) begin
        hist0 <= '0;
        hist1 <= '0;
      end else if (ctrl.sum_en) begin
        hist1 <= hist0;
        hist0 <= sample_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod1 <= coef1 * hist0;
      prod2 <= coef2 * hist1;
    end
    if (ctrl.sum_en) begin
      sample <= sample_next;
    end
  end

endmodule

@@ rtl/sasd_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_mix
// Merge stage: (L+R)*7/10 truncated toward zero and clamped to 16 bits.
// ----------------------------------------------------------------------------
module sasd_mix (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [sasd_pkg::SAMPLE_W-1:0]  left,
  input  logic signed [sasd_pkg::SAMPLE_W-1:0]  right,
  output logic signed [sasd_pkg::SAMPLE_W-1:0]  mix
);

  localparam int PROD_W = 2 * sasd_pkg::MIX_ABS_W;

  logic signed [16:0]                  sum;
  logic signed [19:0]                  times7;
  logic signed [19:0]                  mag_full;
  logic [sasd_pkg::MIX_ABS_W-1:0]      mag;
  logic [PROD_W-1:0]                   prod;
  logic                                neg;
  logic [15:0]                         quot;
  logic signed [16:0]                  value;

  assign sum      = $signed({left[15], left}) + $signed({right[15], right});
  assign times7   = $signed({sum, 3'b000}) - $signed({{3{sum[16]}}, sum});
  assign mag_full = times7[19] ? -times7 : times7;
  assign mag      = mag_full[sasd_pkg::MIX_ABS_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= mag * sasd_pkg::MIX_RECIP;
      neg  <= times7[19];
    end
  end

  assign quot  = prod[sasd_pkg::MIX_SHIFT +: 16];
  assign value = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_comb begin
    if (value > $signed({1'b0, sasd_pkg::SAMPLE_MAX})) begin
      mix = sasd_pkg::SAMPLE_MAX;
    end else if (value < $signed({1'b1, sasd_pkg::SAMPLE_MIN})) begin
      mix = sasd_pkg::SAMPLE_MIN;
    end else begin
      mix = value[sasd_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

@@ rtl/scrambled_adpcm_stereo_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrambled_adpcm_stereo_decoder
// Scrambled 4-bit ADPCM decoder, mono or stereo, with optional L+R mix.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready; result words leave on
// out_valid/out_ready; registers are written on cfg_valid/cfg_ready, which
// is always ready. One input word is worked on at a time; in_ready is high
// only while the controller waits for the next word.
// Start word: no result. Header word: one key update per channel through the
// key multiplier, in S_HDR_L and, in stereo, in S_HDR_R. An end marker on the
// left word skips the key updates and gives its result word from S_END; on
// the right word, after the left key update, through S_HDR_R and S_END.
// Data word: two result words. Each nibble passes the product, sum, mix and
// output states (S_MUL, S_SUM, S_MIX, S_EMIT), which drive the two channel
// lanes and the mix stage; the predictor multiply and the mix multiply each
// take a state of their own, and the product and mix results are registered.
// Results sit in an output register: the next input word is taken while
// the last result still waits. When the receiver stalls, the controller
// holds in its output stage until the register frees.
// Reset clears key, histories, registers and output valid; scales become 1.
// ----------------------------------------------------------------------------
module scrambled_adpcm_stereo_decoder (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [sasd_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [sasd_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [sasd_pkg::OP_W-1:0]                 operation,
  input  logic [15:0]                               left_header,
  input  logic [15:0]                               right_header,
  input  logic [7:0]                                left_byte,
  input  logic [7:0]                                right_byte,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [sasd_pkg::SAMPLE_W-1:0]      left_sample,
  output logic signed [sasd_pkg::SAMPLE_W-1:0]      right_sample,
  output logic                                      stream_end,
  output logic                                      last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR_L = 3'd1;
  localparam logic [2:0] S_HDR_R = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  logic [2:0]                             state;
  logic [2:0]                             state_next;

  logic signed [sasd_pkg::COEF_W-1:0]     coef1;
  logic signed [sasd_pkg::COEF_W-1:0]     coef2;
  logic [sasd_pkg::COEF_W-1:0]            key_mult;
  logic [sasd_pkg::COEF_W-1:0]            key_add;
  logic [sasd_pkg::KEY_W-1:0]             init_key;
  logic                                   stereo;
  logic                                   mix_on;

  logic [sasd_pkg::KEY_W-1:0]             key;
  logic [15:0]                            lword;
  logic [15:0]                            rword;
  logic [7:0]                             lbyte;
  logic [7:0]                             rbyte;
  logic                                   nib_sel;
  logic [sasd_pkg::SCALE_W-1:0]           pend_scale;

  logic                                   in_take;
  logic                                   out_free;
  logic                                   out_load;
  logic [29:0]                            key_prod;
  logic [sasd_pkg::KEY_W-1:0]             key_adv;
  logic [sasd_pkg::SCALE_W-1:0]           lscale_of;
  logic [sasd_pkg::SCALE_W-1:0]           rscale_of;

  sasd_pkg::lane_ctrl_t                   lctrl;
  sasd_pkg::lane_ctrl_t                   rctrl;
  logic [sasd_pkg::SCALE_W-1:0]           lscale_value;
  logic signed [sasd_pkg::NIB_W-1:0]      lnib;
  logic signed [sasd_pkg::NIB_W-1:0]      rnib;
  logic signed [sasd_pkg::SAMPLE_W-1:0]   lsamp;
  logic signed [sasd_pkg::SAMPLE_W-1:0]   rsamp;
  logic signed [sasd_pkg::SAMPLE_W-1:0]   mixv;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == S_EMIT) || (state == S_END));

  assign key_prod  = key * key_mult[sasd_pkg::KEY_W-1:0];
  assign key_adv   = key_prod[sasd_pkg::KEY_W-1:0] + key_add[sasd_pkg::KEY_W-1:0];
  assign lscale_of = {1'b0, lword[12:0] ^ key[12:0]} + sasd_pkg::SCALE_W'(1);
  assign rscale_of = {1'b0, rword[12:0] ^ key[12:0]} + sasd_pkg::SCALE_W'(1);

  assign lnib = nib_sel ? $signed(lbyte[3:0]) : $signed(lbyte[7:4]);
  assign rnib = nib_sel ? $signed(rbyte[3:0]) : $signed(rbyte[7:4]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef1    <= '0;
      coef2    <= '0;
      key_mult <= '0;
      key_add  <= '0;
      init_key <= '0;
      stereo   <= 1'b0;
      mix_on   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sasd_pkg::REG_COEF1:    coef1    <= $signed(cfg_data);
        sasd_pkg::REG_COEF2:    coef2    <= $signed(cfg_data);
        sasd_pkg::REG_KEY_MULT: key_mult <= cfg_data;
        sasd_pkg::REG_KEY_ADD:  key_add  <= cfg_data;
        sasd_pkg::REG_INIT_KEY: init_key <= cfg_data[sasd_pkg::KEY_W-1:0];
        sasd_pkg::REG_STEREO:   stereo   <= cfg_data[0];
        sasd_pkg::REG_MIX:      mix_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          case (operation)
            sasd_pkg::OP_HEADER: state_next = left_header[15] ? S_END : S_HDR_L;
            sasd_pkg::OP_DATA:   state_next = S_MUL;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_HDR_L: state_next = stereo ? S_HDR_R : S_IDLE;
      S_HDR_R: state_next = rword[15] ? S_END : S_IDLE;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_MIX;
      S_MIX:   state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = nib_sel ? S_IDLE : S_MUL;
        end
      end
      S_END: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    lctrl            = '0;
    lctrl.clear      = in_take && (operation == sasd_pkg::OP_START);
    lctrl.scale_load = ((state == S_HDR_L) && !stereo) ||
                       ((state == S_HDR_R) && !rword[15]);
    lctrl.mul_en     = (state == S_MUL);
    lctrl.sum_en     = (state == S_SUM);
    rctrl            = lctrl;
    rctrl.scale_load = (state == S_HDR_R) && !rword[15];
    rctrl.sum_en     = (state == S_SUM) && stereo;
    lscale_value     = (state == S_HDR_R) ? pend_scale : lscale_of;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key       <= '0;
      nib_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take && (operation == sasd_pkg::OP_START)) begin
        key <= init_key;
      end else if ((state == S_HDR_L) || ((state == S_HDR_R) && !rword[15])) begin
        key <= key_adv;
      end
      if (in_take) begin
        nib_sel <= 1'b0;
      end else if ((state == S_EMIT) && out_free) begin
        nib_sel <= !nib_sel;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      lword <= left_header;
      rword <= right_header;
      lbyte <= left_byte;
      rbyte <= right_byte;
    end
    if (state == S_HDR_L) begin
      pend_scale <= lscale_of;
    end
    if (out_load) begin
      if (state == S_END) begin
        left_sample  <= '0;
        right_sample <= '0;
        stream_end   <= 1'b1;
        last         <= 1'b1;
      end else begin
        left_sample  <= (stereo && mix_on) ? mixv : lsamp;
        right_sample <= !stereo ? '0 : (mix_on ? mixv : rsamp);
        stream_end   <= 1'b0;
        last         <= nib_sel;
      end
    end
  end

  sasd_lane u_lane_left (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (lctrl),
    .scale_value (lscale_value),
    .coef1       (coef1),
    .coef2       (coef2),
    .nibble      (lnib),
    .sample      (lsamp)
  );

  sasd_lane u_lane_right (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (rctrl),
    .scale_value (rscale_of),
    .coef1       (coef1),
    .coef2       (coef2),
    .nibble      (rnib),
    .sample      (rsamp)
  );

  sasd_mix u_mix (
    .clk   (clk),
    .en    (state == S_MIX),
    .left  (lsamp),
    .right (rsamp),
    .mix   (mixv)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> last && (left_sample == 0) && (right_sample == 0))
    else $error("end word carries samples");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !stereo |-> (right_sample == 0))
    else $error("mono word with nonzero right sample");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && stereo && mix_on && !stream_end |-> (left_sample == right_sample))
    else $error("mixed word differs between channels");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && out_free && nib_sel |=> (state == S_IDLE) && out_valid && last)
    else $error("second sample not flagged last");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scrambled ADPCM stereo decoder. A queue of
// stream words feeds a valid/ready driver, and an in-bench decoder predicts
// the sample words for every accepted word. The monitor compares each result
// word, field by field, with the oldest prediction. Directed words cover the
// field extremes and the end-marker, start and ignored cases. Random streams
// then run under several register settings and idle/stall patterns, with one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 100;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 48;
  localparam logic [sasd_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [sasd_pkg::OP_W-1:0] op;
    logic [15:0]     lhdr;
    logic [15:0]     rhdr;
    logic [7:0]      lbyte;
    logic [7:0]      rbyte;
  } stream_word_t;

  typedef struct packed {
    logic signed [sasd_pkg::SAMPLE_W-1:0] lsamp;
    logic signed [sasd_pkg::SAMPLE_W-1:0] rsamp;
    logic                                 ended;
    logic                                 last_flag;
  } sample_word_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [sasd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sasd_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic in_valid;
  logic in_ready;
  logic [sasd_pkg::OP_W-1:0] operation;
  logic [15:0] left_header;
  logic [15:0] right_header;
  logic [7:0]  left_byte;
  logic [7:0]  right_byte;
  logic out_valid;
  logic out_ready;
  logic signed [sasd_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [sasd_pkg::SAMPLE_W-1:0] right_sample;
  logic stream_end;
  logic last;

  scrambled_adpcm_stereo_decoder u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation),
    .left_header(left_header), .right_header(right_header),
    .left_byte(left_byte), .right_byte(right_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_sample(left_sample), .right_sample(right_sample),
    .stream_end(stream_end), .last(last)
  );

  stream_word_t word_q[$];
  sample_word_t due_samples[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_start;
  int  hold_left;
  bit  in_accepted;
  int  mismatches;
  int  cycle_count;
  int  queued;

  // decoder model state
  logic signed [sasd_pkg::COEF_W-1:0]   coef_new;
  logic signed [sasd_pkg::COEF_W-1:0]   coef_old;
  logic signed [15:0]                   key_mul;
  logic signed [15:0]                   key_add;
  logic [sasd_pkg::KEY_W-1:0]           key_seed;
  logic                                 stereo_on;
  logic                                 mix_on;
  logic [sasd_pkg::KEY_W-1:0]           key;
  logic signed [sasd_pkg::SAMPLE_W-1:0] hist_l [0:1];
  logic signed [sasd_pkg::SAMPLE_W-1:0] hist_r [0:1];
  logic [sasd_pkg::SCALE_W-1:0]         scale_l;
  logic [sasd_pkg::SCALE_W-1:0]         scale_r;

  sample_word_t got;
  sample_word_t want;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [sasd_pkg::SAMPLE_W-1:0] sat16(longint v);
    if (v > 32767) return sasd_pkg::SAMPLE_MAX;
    if (v < -32768) return sasd_pkg::SAMPLE_MIN;
    return v[sasd_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [sasd_pkg::KEY_W-1:0] next_key(logic [sasd_pkg::KEY_W-1:0] k);
    int p;
    p = int'(k) * int'(key_mul) + int'(key_add);
    return p[sasd_pkg::KEY_W-1:0];
  endfunction

  function automatic logic [sasd_pkg::SCALE_W-1:0] unscramble(logic [15:0] w);
    return {1'b0, w[12:0] ^ key[12:0]} + 14'd1;
  endfunction

  function automatic logic signed [sasd_pkg::SAMPLE_W-1:0] decode_nibble(
    logic [sasd_pkg::NIB_W-1:0] nib, logic [sasd_pkg::SCALE_W-1:0] scale,
    logic signed [sasd_pkg::SAMPLE_W-1:0] h1, logic signed [sasd_pkg::SAMPLE_W-1:0] h2);
    longint pred;
    longint v;
    pred = longint'(coef_new) * longint'(h1) + longint'(coef_old) * longint'(h2);
    v = longint'(signed'(nib)) * longint'(scale) + (pred >>> sasd_pkg::PRED_SHIFT);
    return sat16(v);
  endfunction

  function automatic logic signed [sasd_pkg::SAMPLE_W-1:0] mix_pair(
    logic signed [sasd_pkg::SAMPLE_W-1:0] l, logic signed [sasd_pkg::SAMPLE_W-1:0] r);
    return sat16((longint'(l) + longint'(r)) * 7 / 10);
  endfunction

  task automatic model_reset();
    coef_new  = '0;
    coef_old  = '0;
    key_mul   = '0;
    key_add   = '0;
    key_seed  = '0;
    stereo_on = 1'b0;
    mix_on    = 1'b0;
    key       = '0;
    hist_l[0] = '0;
    hist_l[1] = '0;
    hist_r[0] = '0;
    hist_r[1] = '0;
    scale_l   = 14'd1;
    scale_r   = 14'd1;
  endtask

  task automatic decode_word(stream_word_t w);
    logic [sasd_pkg::SCALE_W-1:0] ls;
    logic signed [sasd_pkg::SAMPLE_W-1:0] l;
    logic signed [sasd_pkg::SAMPLE_W-1:0] r;
    int k;
    case (w.op)
      sasd_pkg::OP_START: begin
        key = key_seed;
        hist_l[0] = '0;
        hist_l[1] = '0;
        hist_r[0] = '0;
        hist_r[1] = '0;
      end
      sasd_pkg::OP_HEADER: begin
        if (w.lhdr[15]) begin
          due_samples.push_back('{16'sd0, 16'sd0, 1'b1, 1'b1});
        end else if (!stereo_on) begin
          scale_l = unscramble(w.lhdr);
          key = next_key(key);
        end else begin
          ls = unscramble(w.lhdr);
          key = next_key(key);
          if (w.rhdr[15]) begin
            due_samples.push_back('{16'sd0, 16'sd0, 1'b1, 1'b1});
          end else begin
            scale_l = ls;
            scale_r = unscramble(w.rhdr);
            key = next_key(key);
          end
        end
      end
      sasd_pkg::OP_DATA: begin
        for (k = 0; k < 2; k++) begin
          l = decode_nibble(k == 0 ? w.lbyte[7:4] : w.lbyte[3:0], scale_l,
                            hist_l[0], hist_l[1]);
          hist_l[1] = hist_l[0];
          hist_l[0] = l;
          r = '0;
          if (stereo_on) begin
            r = decode_nibble(k == 0 ? w.rbyte[7:4] : w.rbyte[3:0], scale_r,
                              hist_r[0], hist_r[1]);
            hist_r[1] = hist_r[0];
            hist_r[0] = r;
            if (mix_on) begin
              l = mix_pair(l, r);
              r = l;
            end
          end
          due_samples.push_back('{l, r, 1'b0, k == 1});
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      if (mismatches < MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      model_reset();
      due_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sasd_pkg::REG_COEF1:    coef_new  = cfg_data;
          sasd_pkg::REG_COEF2:    coef_old  = cfg_data;
          sasd_pkg::REG_KEY_MULT: key_mul   = cfg_data;
          sasd_pkg::REG_KEY_ADD:  key_add   = cfg_data;
          sasd_pkg::REG_INIT_KEY: key_seed  = cfg_data[sasd_pkg::KEY_W-1:0];
          sasd_pkg::REG_STEREO:   stereo_on = cfg_data[0];
          sasd_pkg::REG_MIX:      mix_on    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_word('{operation, left_header, right_header, left_byte, right_byte});
        in_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = '{left_sample, right_sample, stream_end, last};
        if (due_samples.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $error("result word with no prediction: left %0d right %0d end %0b last %0b",
                   got.lsamp, got.rsamp, got.ended, got.last_flag);
          mismatches++;
        end else begin
          want = due_samples.pop_front();
          compare_field("left_sample", want.lsamp, got.lsamp);
          compare_field("right_sample", want.rsamp, got.rsamp);
          compare_field("stream_end", want.ended, got.ended);
          compare_field("last", want.last_flag, got.last_flag);
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {operation, left_header, right_header, left_byte, right_byte} = word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_accepted = 1'b0;
  end

  // receiver with optional long hold-off
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_word(logic [sasd_pkg::OP_W-1:0] op, logic [15:0] lh,
                            logic [15:0] rh, logic [7:0] lb, logic [7:0] rb);
    word_q.push_back('{op, lh, rh, lb, rb});
    if (op != OP_IGNORED) queued++;
  endtask

  task automatic queue_stream();
    int n;
    if ($urandom_range(4) != 0)
      queue_word(sasd_pkg::OP_START, 16'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom));
    queue_word(sasd_pkg::OP_HEADER, {1'b0, 15'($urandom)}, {1'b0, 15'($urandom)},
               8'($urandom), 8'($urandom));
    n = $urandom_range(1, 6);
    repeat (n) queue_word(sasd_pkg::OP_DATA, 16'($urandom), 16'($urandom),
                          8'($urandom), 8'($urandom));
    if ($urandom_range(6) == 0) begin
      if ($urandom_range(1))
        queue_word(sasd_pkg::OP_HEADER, {1'b1, 15'($urandom)}, 16'($urandom),
                   8'($urandom), 8'($urandom));
      else
        queue_word(sasd_pkg::OP_HEADER, {1'b0, 15'($urandom)}, {1'b1, 15'($urandom)},
                   8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (word_q.size() != 0 || in_valid || due_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [sasd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [sasd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic write_setting(logic [15:0] c1, logic [15:0] c2, logic [15:0] mul,
                               logic [15:0] add, logic [15:0] seed, logic st, logic mx);
    write_reg(sasd_pkg::REG_COEF1, c1);
    write_reg(sasd_pkg::REG_COEF2, c2);
    write_reg(sasd_pkg::REG_KEY_MULT, mul);
    write_reg(sasd_pkg::REG_KEY_ADD, add);
    write_reg(sasd_pkg::REG_INIT_KEY, seed);
    write_reg(sasd_pkg::REG_STEREO, {15'd0, st});
    write_reg(sasd_pkg::REG_MIX, {15'd0, mx});
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pace(int mode);
    case (mode)
      1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
      3:       begin send_idle_pct = 38; recv_stall_pct = 38; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    int p;
    logic [15:0] c1;
    logic [15:0] c2;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = '0;
    left_header = '0;
    right_header = '0;
    left_byte = '0;
    right_byte = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    hold_left = 0;
    in_accepted = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    queued = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: data before any header, an ignored word, mono headers, a start, end markers
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h7F, 8'h80);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h88, 8'hFF);
    queue_word(OP_IGNORED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    queue_word(sasd_pkg::OP_HEADER, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h0F, 8'hF0);
    queue_word(sasd_pkg::OP_HEADER, 16'h8000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_HEADER, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    drain();

    // stereo with mix, extreme coefficients and key constants
    write_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
    queue_word(sasd_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_HEADER, 16'h1FFF, 16'h7FFF, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h77, 8'h77);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h88, 8'h88);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h80, 8'h7F);
    queue_word(sasd_pkg::OP_HEADER, 16'h1234, 16'h8000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h00, 8'hFF);
    queue_word(sasd_pkg::OP_HEADER, 16'h7FFF, 16'hFFFF, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_HEADER, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
    drain();

    write_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
    queue_word(sasd_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_HEADER, 16'h0000, 16'h1FFF, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'hF0, 8'h0F);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'h7F, 8'h80);
    queue_word(OP_IGNORED, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(sasd_pkg::OP_DATA, 16'h0000, 16'h0000, 8'hFF, 8'h00);
    drain();

    for (p = 0; p < PHASES; p++) begin
      c1 = (p % 2) ? 16'($urandom) : 16'($urandom_range(1024, 8000));
      c2 = (p % 2) ? 16'($urandom) : 16'(-int'($urandom_range(0, 4000)));
      write_setting(c1, c2, 16'($urandom), 16'($urandom), {1'b0, 15'($urandom)},
                    p % 3 != 0, p[1]);
      set_pace(p % 4);
      if (p == 4) hold_start = 1'b1;
      queued = 0;
      while (queued < PHASE_WORDS) begin
        if ($urandom_range(99) < 85)
          queue_stream();
        else
          queue_word(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom));
      end
      drain();
    end

    if (mismatches == 0 && due_samples.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sasd_pkg.sv
rtl/sasd_lane.sv
rtl/sasd_mix.sv
rtl/scrambled_adpcm_stereo_decoder.sv
tb/tb.sv
